// ----- design/rc_frame_receiver_failsafe_top_macros.svh -----
// assertion macros for the rc frame receiver
`ifndef RC_FRAME_RECEIVER_FAILSAFE_TOP_MACROS_SVH
`define RC_FRAME_RECEIVER_FAILSAFE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define RCFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcfr assertion failed");
// next-cycle implication, checked out of reset
`define RCFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcfr assertion failed");
`else
`define RCFR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RCFR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/rcfr_pkg.sv -----
`default_nettype none
package rcfr_pkg;

  // frame layout
  localparam int FRAME_LEN = 12;
  localparam int STORE_LEN = FRAME_LEN - 1;
  localparam int POS_W = 4;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] END_POS = POS_W'(FRAME_LEN);

  // frame flags and check byte
  localparam logic [7:0] CHECK_BYTE = 8'hA5;
  localparam logic [7:0] STICK_FLAG = 8'h01;
  localparam logic [7:0] BUTTON_FLAG = 8'h08;
  localparam logic [3:0] CAL_FLAG = 4'h4;

  // failsafe descent
  localparam logic signed [15:0] DESCENT_STEP = 16'sd6;
  localparam logic signed [15:0] THROTTLE_FLOOR = 16'sd150;
  localparam logic [7:0] ID_RESET = 8'd250;

  // input op codes
  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_APP  = 2'd2
  } op_t;

  // led commands
  typedef enum logic [1:0] {
    LED_NONE = 2'd0,
    LED_FLY  = 2'd1,
    LED_OFF  = 2'd2,
    LED_RED  = 2'd3
  } led_t;

  // wifi led codes
  typedef enum logic [1:0] {
    WIFI_NONE = 2'd0,
    WIFI_ON   = 2'd1,
    WIFI_OFF  = 2'd2
  } wifi_code_t;

  // command kinds handed from front to back
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_FRAME = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_APP   = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        check_ok;
    logic        stick;
    logic        button;
    logic [3:0]  buttons;
    logic [15:0] yaw;
    logic [15:0] throttle;
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [7:0]  packet_id;
    logic        batt;
  } cmd_t;

endpackage
`default_nettype wire

// ----- design/rcfr_front.sv -----
`default_nettype none
module rcfr_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_op,
  input  wire logic [7:0]    in_rx_byte,
  input  wire logic          in_frame_start,
  input  wire logic          in_battery_led_on,
  output logic               push,
  output rcfr_pkg::cmd_t     cmd,
  input  wire logic          q_ready
);
  import rcfr_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt, pos_eff;
  logic [7:0]       store_r [STORE_LEN];
  logic             accept;
  logic             is_byte;

  assign in_ready = q_ready;
  assign accept   = in_valid & q_ready;
  assign push     = accept;
  assign is_byte  = (in_op == OP_BYTE);

  // position of this byte, restarted by frame start
  assign pos_eff = in_frame_start ? '0 : pos_r;

  // classify the item
  always_comb begin
    pos_nxt       = pos_r;
    cmd           = '0;
    cmd.kind      = CMD_NONE;
    cmd.batt      = in_battery_led_on;
    cmd.check_ok  = (in_rx_byte == CHECK_BYTE);
    cmd.stick     = |(store_r[0] & STICK_FLAG);
    cmd.button    = |(store_r[0] & BUTTON_FLAG);
    cmd.buttons   = store_r[1][3:0];
    cmd.yaw       = {store_r[3], store_r[2]};
    cmd.throttle  = {store_r[5], store_r[4]};
    cmd.roll      = {store_r[7], store_r[6]};
    cmd.pitch     = {store_r[9], store_r[8]};
    cmd.packet_id = store_r[10];
    unique case (in_op)
      OP_BYTE: begin
        if (pos_eff < END_POS) begin
          pos_nxt = pos_eff + 1'b1;
          if (pos_eff == LAST_POS) begin
            cmd.kind = CMD_FRAME;
          end
        end
      end
      OP_TICK: cmd.kind = CMD_TICK;
      OP_APP:  cmd.kind = CMD_APP;
      default: cmd.kind = CMD_NONE;
    endcase
  end

  // byte position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

  // frame store, check byte is not kept
  always_ff @(posedge clk) begin
    if (accept && is_byte && (pos_eff < LAST_POS)) begin
      store_r[pos_eff] <= in_rx_byte;
    end
  end

endmodule
`default_nettype wire

// ----- design/rcfr_queue.sv -----
`default_nettype none
module rcfr_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  output logic                push_ready,
  input  wire rcfr_pkg::cmd_t push_cmd,
  output logic                pop_valid,
  input  wire logic           pop,
  output rcfr_pkg::cmd_t      pop_cmd
);
  import rcfr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  cmd_t          entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push & push_ready;
  assign do_pop     = pop & pop_valid;

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ----- design/rcfr_back.sv -----
`default_nettype none
`include "rc_frame_receiver_failsafe_top_macros.svh"
module rcfr_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  output logic                cmd_pop,
  input  wire rcfr_pkg::cmd_t cmd,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                out_frame_accepted,
  output logic signed [15:0]  out_yaw_out,
  output logic signed [15:0]  out_throttle_out,
  output logic signed [15:0]  out_roll_out,
  output logic signed [15:0]  out_pitch_out,
  output logic                out_armed_out,
  output logic                out_wifi_enable_out,
  output logic [1:0]          out_wifi_led_code,
  output logic                out_gyro_cal_request,
  output logic                out_headless_mode,
  output logic [1:0]          out_led_command
);
  import rcfr_pkg::*;

  logic              out_valid_r;
  logic              acc_r, acc_nxt;
  logic              cal_r, cal_nxt;
  led_t              led_r, led_nxt;
  logic signed [15:0] yaw_r, yaw_nxt, thr_r, thr_nxt, roll_r, roll_nxt, pitch_r, pitch_nxt;
  logic signed [15:0] thr_desc;
  logic [7:0]        latest_r, latest_nxt, checked_r, checked_nxt;
  logic [3:0]        prev_r, prev_nxt, diff;
  logic              armed_r, armed_nxt, wifi_r, wifi_nxt, head_r, head_nxt;
  logic              app_r, app_nxt;
  wifi_code_t        wcode_r, wcode_nxt;

  // take a command whenever the result slot is free or being emptied
  assign cmd_pop = cmd_valid & (!out_valid_r | out_ready);

  assign diff = prev_r ^ cmd.buttons;

  // failsafe throttle descent with floor
  assign thr_desc = (thr_r <= (THROTTLE_FLOOR + DESCENT_STEP)) ? THROTTLE_FLOOR
                                                              : thr_r - DESCENT_STEP;

  // execute one command
  always_comb begin
    acc_nxt     = 1'b0;
    cal_nxt     = 1'b0;
    led_nxt     = LED_NONE;
    yaw_nxt     = yaw_r;
    thr_nxt     = thr_r;
    roll_nxt    = roll_r;
    pitch_nxt   = pitch_r;
    latest_nxt  = latest_r;
    checked_nxt = checked_r;
    prev_nxt    = prev_r;
    armed_nxt   = armed_r;
    wifi_nxt    = wifi_r;
    wcode_nxt   = wcode_r;
    head_nxt    = head_r;
    app_nxt     = app_r;
    unique case (cmd.kind)
      CMD_FRAME: begin
        app_nxt = 1'b0;
        if (cmd.check_ok) begin
          acc_nxt    = 1'b1;
          latest_nxt = cmd.packet_id;
          if (cmd.stick) begin
            yaw_nxt   = cmd.yaw;
            thr_nxt   = cmd.throttle;
            roll_nxt  = cmd.roll;
            pitch_nxt = cmd.pitch;
          end else if (cmd.button) begin
            if (diff[0]) begin
              armed_nxt = cmd.buttons[0];
              led_nxt   = LED_OFF;
            end
            if (diff[1]) begin
              wifi_nxt  = cmd.buttons[1];
              wcode_nxt = cmd.buttons[1] ? WIFI_ON : WIFI_OFF;
            end
            cal_nxt = |(cmd.buttons & CAL_FLAG) & !armed_nxt;
            if (diff[3]) begin
              head_nxt = cmd.buttons[3];
            end
            prev_nxt = cmd.buttons;
          end
        end
      end
      CMD_TICK: begin
        if (!app_r) begin
          if (armed_r && (latest_r == checked_r)) begin
            thr_nxt = thr_desc;
            led_nxt = LED_RED;
          end else begin
            if (armed_r && !cmd.batt) begin
              led_nxt = LED_FLY;
            end
            checked_nxt = latest_r;
          end
        end
      end
      CMD_APP:  app_nxt = 1'b1;
      CMD_NONE: app_nxt = app_r;
      default:  app_nxt = app_r;
    endcase
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      acc_r       <= 1'b0;
      cal_r       <= 1'b0;
      led_r       <= LED_NONE;
      yaw_r       <= '0;
      thr_r       <= '0;
      roll_r      <= '0;
      pitch_r     <= '0;
      latest_r    <= '0;
      checked_r   <= ID_RESET;
      prev_r      <= '0;
      armed_r     <= 1'b0;
      wifi_r      <= 1'b0;
      wcode_r     <= WIFI_NONE;
      head_r      <= 1'b0;
      app_r       <= 1'b0;
    end else begin
      if (cmd_pop) begin
        out_valid_r <= 1'b1;
        acc_r       <= acc_nxt;
        cal_r       <= cal_nxt;
        led_r       <= led_nxt;
        yaw_r       <= yaw_nxt;
        thr_r       <= thr_nxt;
        roll_r      <= roll_nxt;
        pitch_r     <= pitch_nxt;
        latest_r    <= latest_nxt;
        checked_r   <= checked_nxt;
        prev_r      <= prev_nxt;
        armed_r     <= armed_nxt;
        wifi_r      <= wifi_nxt;
        wcode_r     <= wcode_nxt;
        head_r      <= head_nxt;
        app_r       <= app_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word
  assign out_valid            = out_valid_r;
  assign out_frame_accepted   = acc_r;
  assign out_yaw_out          = yaw_r;
  assign out_throttle_out     = thr_r;
  assign out_roll_out         = roll_r;
  assign out_pitch_out        = pitch_r;
  assign out_armed_out        = armed_r;
  assign out_wifi_enable_out  = wifi_r;
  assign out_wifi_led_code    = wcode_r;
  assign out_gyro_cal_request = cal_r;
  assign out_headless_mode    = head_r;
  assign out_led_command      = led_r;

  // checks on the executed result
  `RCFR_ASSERT_IMP(a_red_floor, clk, rst_n, out_valid_r && (led_r == LED_RED), thr_r >= THROTTLE_FLOOR)
  `RCFR_ASSERT_IMP(a_cal_disarmed, clk, rst_n, out_valid_r && cal_r, acc_r && !armed_r)
  `RCFR_ASSERT_IMP(a_fly_armed, clk, rst_n, out_valid_r && (led_r == LED_FLY), armed_r)
  `RCFR_ASSERT_IMP(a_frame_app, clk, rst_n, out_valid_r && acc_r, !app_r)
  `RCFR_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid_r && !out_ready, out_valid_r && $stable(thr_r) && $stable(armed_r))

endmodule
`default_nettype wire

// ----- design/rc_frame_receiver_failsafe_top.sv -----
// rc frame receiver with link-loss failsafe
// an accepted item is written into the queue, then popped and executed into the back-end result register
// throughput: one item per cycle while out_ready does not stall the result, set by the state update in the back end
// the queue between front and back holds QUEUE_DEPTH commands
// reset: synchronous, active low; channels, buttons and flags cleared, checked id 250
// frame store is not cleared and needs no clearing pass
`default_nettype none
module rc_frame_receiver_failsafe_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_op,
  input  wire logic [7:0]    in_rx_byte,
  input  wire logic          in_frame_start,
  input  wire logic          in_battery_led_on,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_frame_accepted,
  output logic signed [15:0] out_yaw_out,
  output logic signed [15:0] out_throttle_out,
  output logic signed [15:0] out_roll_out,
  output logic signed [15:0] out_pitch_out,
  output logic               out_armed_out,
  output logic               out_wifi_enable_out,
  output logic [1:0]         out_wifi_led_code,
  output logic               out_gyro_cal_request,
  output logic               out_headless_mode,
  output logic [1:0]         out_led_command
);
  import rcfr_pkg::*;

  logic push, q_ready, q_valid, q_pop;
  cmd_t push_cmd, q_cmd;

  // framing and classification
  rcfr_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_rx_byte        (in_rx_byte),
    .in_frame_start    (in_frame_start),
    .in_battery_led_on (in_battery_led_on),
    .push              (push),
    .cmd               (push_cmd),
    .q_ready           (q_ready)
  );

  // command queue
  rcfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (q_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  // state update and result register
  rcfr_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd_valid            (q_valid),
    .cmd_pop              (q_pop),
    .cmd                  (q_cmd),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_frame_accepted   (out_frame_accepted),
    .out_yaw_out          (out_yaw_out),
    .out_throttle_out     (out_throttle_out),
    .out_roll_out         (out_roll_out),
    .out_pitch_out        (out_pitch_out),
    .out_armed_out        (out_armed_out),
    .out_wifi_enable_out  (out_wifi_enable_out),
    .out_wifi_led_code    (out_wifi_led_code),
    .out_gyro_cal_request (out_gyro_cal_request),
    .out_headless_mode    (out_headless_mode),
    .out_led_command      (out_led_command)
  );

endmodule
`default_nettype wire
